// ----- sv/afc_pkg.sv -----
// Package for the box versus clip-plane classifier.
// Holds the shared codes, reset values, defaults and the control struct that travels
// between the cells. No dependencies.
package afc_pkg;

    typedef enum logic
    {
        OP_TEST = 1'b0,
        OP_LOAD = 1'b1
    } afc_op_t;

    typedef enum logic
    {
        REG_PLANE_COUNT = 1'b0,
        REG_CORNER_CODES = 1'b1
    } afc_reg_t;

    localparam logic [1:0] VERDICT_OUTSIDE = 2'd0;
    localparam logic [1:0] VERDICT_INTERSECT = 2'd1;
    localparam logic [1:0] VERDICT_INSIDE = 2'd2;

    localparam int PLANE_SLOTS_DEFAULT = 7;
    localparam int COORD_WIDTH_DEFAULT = 32;

    localparam int FAR_PLANE_INDEX = 5;
    localparam int CODE_PLANES = 7;
    localparam int OFFSET_SHIFT = 16;

    localparam int COUNT_WIDTH = 3;
    localparam int CODE_WIDTH = 4;
    localparam int CODES_WIDTH = CODE_PLANES * CODE_WIDTH;
    localparam int SLOT_WIDTH = 3;
    localparam int ADDR_WIDTH = 3;
    localparam int DATA_WIDTH = 32;

    localparam logic [COUNT_WIDTH-1:0] PLANE_COUNT_RESET = 3'd6;
    localparam logic [CODES_WIDTH-1:0] CORNER_CODES_RESET = 28'hFFFFFFF;

    typedef struct packed
    {
        afc_op_t op;
        logic skip_far;
        logic [SLOT_WIDTH-1:0] slot;
        logic outside;
        logic inter;
    } afc_ctl_t;

endpackage

// ----- sv/aabb_frustum_cull_core.sv -----
// Top level of the box versus clip-plane classifier: configuration registers, cell chain
// and result register. Depends on afc_pkg and afc_cell.
//
// Channel   Direction  Handshake             Contents
// input     in         in_valid / in_ready   operation, skip_far, plane_slot, vectors, extents
// output    out        out_valid / out_ready verdict
// config    in         APB write/read        active_plane_count, corner_codes
//
// One transaction enters per cycle while in_ready is high; a test result passes through the
// three stages in each cell of the chain, the last of which feeds the result register.
// Reset clears the plane table, the valid bits and the registers to their reset values.
// Each stage holds its transaction while the stage after it is full and cannot advance, so
// stalls only back up as far as the first empty stage.
module aabb_frustum_cull_core #(
    parameter int PLANE_SLOTS = afc_pkg::PLANE_SLOTS_DEFAULT,
    parameter int COORD_WIDTH = afc_pkg::COORD_WIDTH_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [afc_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [afc_pkg::DATA_WIDTH-1:0] pwdata,
    output logic [afc_pkg::DATA_WIDTH-1:0] prdata,
    output logic pready,
    input  logic in_valid,
    output logic in_ready,
    input  logic operation,
    input  logic skip_far,
    input  logic [afc_pkg::SLOT_WIDTH-1:0] plane_slot,
    input  logic signed [COORD_WIDTH-1:0] vec_x,
    input  logic signed [COORD_WIDTH-1:0] vec_y,
    input  logic signed [COORD_WIDTH-1:0] vec_z,
    input  logic [COORD_WIDTH-2:0] extent_x,
    input  logic [COORD_WIDTH-2:0] extent_y,
    input  logic [COORD_WIDTH-2:0] extent_z,
    input  logic signed [COORD_WIDTH-1:0] plane_offset,
    output logic out_valid,
    input  logic out_ready,
    output logic [1:0] verdict
);

    logic [afc_pkg::COUNT_WIDTH-1:0] plane_count_reg;
    logic [afc_pkg::CODES_WIDTH-1:0] corner_codes_reg;
    afc_pkg::afc_reg_t reg_sel;
    logic cfg_write;

    logic chain_valid [PLANE_SLOTS+1];
    logic chain_ready [PLANE_SLOTS+1];
    afc_pkg::afc_ctl_t chain_ctl [PLANE_SLOTS+1];
    logic signed [COORD_WIDTH-1:0] chain_vx [PLANE_SLOTS+1];
    logic signed [COORD_WIDTH-1:0] chain_vy [PLANE_SLOTS+1];
    logic signed [COORD_WIDTH-1:0] chain_vz [PLANE_SLOTS+1];
    logic [COORD_WIDTH-2:0] chain_ex [PLANE_SLOTS+1];
    logic [COORD_WIDTH-2:0] chain_ey [PLANE_SLOTS+1];
    logic [COORD_WIDTH-2:0] chain_ez [PLANE_SLOTS+1];
    logic signed [COORD_WIDTH-1:0] chain_off [PLANE_SLOTS+1];

    afc_pkg::afc_ctl_t entry_ctl;
    afc_pkg::afc_ctl_t last_ctl;
    logic last_take;

    logic out_valid_reg;
    logic out_valid_next;
    logic [1:0] verdict_reg;
    logic [1:0] verdict_next;

    assign reg_sel = afc_pkg::afc_reg_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_count_reg <= afc_pkg::PLANE_COUNT_RESET;
            corner_codes_reg <= afc_pkg::CORNER_CODES_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                afc_pkg::REG_PLANE_COUNT:
                begin
                    plane_count_reg <= pwdata[afc_pkg::COUNT_WIDTH-1:0];
                end
                afc_pkg::REG_CORNER_CODES:
                begin
                    corner_codes_reg <= pwdata[afc_pkg::CODES_WIDTH-1:0];
                end
                default:
                begin
                    plane_count_reg <= plane_count_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            afc_pkg::REG_PLANE_COUNT:
            begin
                prdata = afc_pkg::DATA_WIDTH'(plane_count_reg);
            end
            afc_pkg::REG_CORNER_CODES:
            begin
                prdata = afc_pkg::DATA_WIDTH'(corner_codes_reg);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_comb
    begin
        entry_ctl.op = afc_pkg::afc_op_t'(operation);
        entry_ctl.skip_far = skip_far;
        entry_ctl.slot = plane_slot;
        entry_ctl.outside = 1'b0;
        entry_ctl.inter = 1'b0;
    end

    assign chain_valid[0] = in_valid;
    assign in_ready = chain_ready[0];
    assign chain_ctl[0] = entry_ctl;
    assign chain_vx[0] = vec_x;
    assign chain_vy[0] = vec_y;
    assign chain_vz[0] = vec_z;
    assign chain_ex[0] = extent_x;
    assign chain_ey[0] = extent_y;
    assign chain_ez[0] = extent_z;
    assign chain_off[0] = plane_offset;

    for (genvar i = 0; i < PLANE_SLOTS; i++)
    begin : g_cell
        afc_cell #(
            .INDEX(i),
            .COORD_WIDTH(COORD_WIDTH)
        ) u_cell (
            .clk(clk),
            .rst_n(rst_n),
            .active_plane_count(plane_count_reg),
            .corner_codes(corner_codes_reg),
            .in_valid(chain_valid[i]),
            .in_ready(chain_ready[i]),
            .in_ctl(chain_ctl[i]),
            .in_vec_x(chain_vx[i]),
            .in_vec_y(chain_vy[i]),
            .in_vec_z(chain_vz[i]),
            .in_ext_x(chain_ex[i]),
            .in_ext_y(chain_ey[i]),
            .in_ext_z(chain_ez[i]),
            .in_offset(chain_off[i]),
            .out_valid(chain_valid[i+1]),
            .out_ready(chain_ready[i+1]),
            .out_ctl(chain_ctl[i+1]),
            .out_vec_x(chain_vx[i+1]),
            .out_vec_y(chain_vy[i+1]),
            .out_vec_z(chain_vz[i+1]),
            .out_ext_x(chain_ex[i+1]),
            .out_ext_y(chain_ey[i+1]),
            .out_ext_z(chain_ez[i+1]),
            .out_offset(chain_off[i+1])
        );
    end

    assign last_ctl = chain_ctl[PLANE_SLOTS];
    assign chain_ready[PLANE_SLOTS] = !out_valid_reg || out_ready;
    assign last_take = chain_valid[PLANE_SLOTS] && chain_ready[PLANE_SLOTS]
                       && (last_ctl.op == afc_pkg::OP_TEST);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (last_take)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_comb
    begin
        if (last_ctl.outside)
        begin
            verdict_next = afc_pkg::VERDICT_OUTSIDE;
        end
        else if (last_ctl.inter)
        begin
            verdict_next = afc_pkg::VERDICT_INTERSECT;
        end
        else
        begin
            verdict_next = afc_pkg::VERDICT_INSIDE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (last_take)
        begin
            verdict_reg <= verdict_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign verdict = verdict_reg;

endmodule

// ----- sv/afc_cell.sv -----
// One cell of the classifier chain: holds one plane entry and tests boxes if it is enabled.
// Three internal stages: products, sums, crossing decision. Depends on afc_pkg.
module afc_cell #(
    parameter int INDEX = 0,
    parameter int COORD_WIDTH = afc_pkg::COORD_WIDTH_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    input  logic [afc_pkg::COUNT_WIDTH-1:0] active_plane_count,
    input  logic [afc_pkg::CODES_WIDTH-1:0] corner_codes,
    input  logic in_valid,
    output logic in_ready,
    input  afc_pkg::afc_ctl_t in_ctl,
    input  logic signed [COORD_WIDTH-1:0] in_vec_x,
    input  logic signed [COORD_WIDTH-1:0] in_vec_y,
    input  logic signed [COORD_WIDTH-1:0] in_vec_z,
    input  logic [COORD_WIDTH-2:0] in_ext_x,
    input  logic [COORD_WIDTH-2:0] in_ext_y,
    input  logic [COORD_WIDTH-2:0] in_ext_z,
    input  logic signed [COORD_WIDTH-1:0] in_offset,
    output logic out_valid,
    input  logic out_ready,
    output afc_pkg::afc_ctl_t out_ctl,
    output logic signed [COORD_WIDTH-1:0] out_vec_x,
    output logic signed [COORD_WIDTH-1:0] out_vec_y,
    output logic signed [COORD_WIDTH-1:0] out_vec_z,
    output logic [COORD_WIDTH-2:0] out_ext_x,
    output logic [COORD_WIDTH-2:0] out_ext_y,
    output logic [COORD_WIDTH-2:0] out_ext_z,
    output logic signed [COORD_WIDTH-1:0] out_offset
);

    localparam int PROD_W = 2 * COORD_WIDTH;
    localparam int ACC_W = 2 * COORD_WIDTH + 2;
    localparam int SUM_W = ACC_W + 1;

    logic signed [COORD_WIDTH-1:0] nx_reg;
    logic signed [COORD_WIDTH-1:0] ny_reg;
    logic signed [COORD_WIDTH-1:0] nz_reg;
    logic signed [COORD_WIDTH-1:0] nw_reg;

    logic [afc_pkg::CODE_WIDTH-1:0] code;
    logic test_en;
    logic load_hit;
    logic rdy1;
    logic rdy2;
    logic rdy3;

    logic s1_valid_reg;
    afc_pkg::afc_ctl_t s1_ctl_reg;
    logic s1_en_reg;
    logic [2:0] s1_sgn_reg;
    logic signed [PROD_W-1:0] s1_pcx_reg;
    logic signed [PROD_W-1:0] s1_pcy_reg;
    logic signed [PROD_W-1:0] s1_pcz_reg;
    logic signed [PROD_W-1:0] s1_pex_reg;
    logic signed [PROD_W-1:0] s1_pey_reg;
    logic signed [PROD_W-1:0] s1_pez_reg;
    logic signed [COORD_WIDTH-1:0] s1_w_reg;
    logic signed [COORD_WIDTH-1:0] s1_vx_reg;
    logic signed [COORD_WIDTH-1:0] s1_vy_reg;
    logic signed [COORD_WIDTH-1:0] s1_vz_reg;
    logic [COORD_WIDTH-2:0] s1_ex_reg;
    logic [COORD_WIDTH-2:0] s1_ey_reg;
    logic [COORD_WIDTH-2:0] s1_ez_reg;
    logic signed [COORD_WIDTH-1:0] s1_off_reg;

    logic signed [ACC_W-1:0] a_next;
    logic signed [ACC_W-1:0] b_next;

    logic s2_valid_reg;
    afc_pkg::afc_ctl_t s2_ctl_reg;
    logic s2_en_reg;
    logic signed [ACC_W-1:0] s2_a_reg;
    logic signed [ACC_W-1:0] s2_b_reg;
    logic signed [COORD_WIDTH-1:0] s2_vx_reg;
    logic signed [COORD_WIDTH-1:0] s2_vy_reg;
    logic signed [COORD_WIDTH-1:0] s2_vz_reg;
    logic [COORD_WIDTH-2:0] s2_ex_reg;
    logic [COORD_WIDTH-2:0] s2_ey_reg;
    logic [COORD_WIDTH-2:0] s2_ez_reg;
    logic signed [COORD_WIDTH-1:0] s2_off_reg;

    logic signed [SUM_W-1:0] near_dist;
    logic signed [SUM_W-1:0] far_dist;
    afc_pkg::afc_ctl_t ctl3_next;

    logic s3_valid_reg;
    afc_pkg::afc_ctl_t s3_ctl_reg;
    logic signed [COORD_WIDTH-1:0] s3_vx_reg;
    logic signed [COORD_WIDTH-1:0] s3_vy_reg;
    logic signed [COORD_WIDTH-1:0] s3_vz_reg;
    logic [COORD_WIDTH-2:0] s3_ex_reg;
    logic [COORD_WIDTH-2:0] s3_ey_reg;
    logic [COORD_WIDTH-2:0] s3_ez_reg;
    logic signed [COORD_WIDTH-1:0] s3_off_reg;

    if (INDEX < afc_pkg::CODE_PLANES)
    begin : g_code
        assign code = corner_codes[afc_pkg::CODE_WIDTH*INDEX +: afc_pkg::CODE_WIDTH];
    end
    else
    begin : g_no_code
        assign code = '1;
    end

    assign rdy3 = !s3_valid_reg || out_ready;
    assign rdy2 = !s2_valid_reg || rdy3;
    assign rdy1 = !s1_valid_reg || rdy2;
    assign in_ready = rdy1;

    assign test_en = (in_ctl.op == afc_pkg::OP_TEST)
                     && (32'(active_plane_count) > INDEX)
                     && !(in_ctl.skip_far && (INDEX == afc_pkg::FAR_PLANE_INDEX))
                     && !code[afc_pkg::CODE_WIDTH-1];

    assign load_hit = in_valid && rdy1 && (in_ctl.op == afc_pkg::OP_LOAD)
                      && (32'(in_ctl.slot) == INDEX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_reg <= '0;
            ny_reg <= '0;
            nz_reg <= '0;
            nw_reg <= '0;
        end
        else if (load_hit)
        begin
            nx_reg <= in_vec_x;
            ny_reg <= in_vec_y;
            nz_reg <= in_vec_z;
            nw_reg <= in_offset;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (rdy2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rdy3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            s1_ctl_reg <= in_ctl;
            s1_en_reg <= test_en;
            s1_sgn_reg <= code[2:0];
            s1_pcx_reg <= nx_reg * in_vec_x;
            s1_pcy_reg <= ny_reg * in_vec_y;
            s1_pcz_reg <= nz_reg * in_vec_z;
            s1_pex_reg <= nx_reg * $signed({1'b0, in_ext_x});
            s1_pey_reg <= ny_reg * $signed({1'b0, in_ext_y});
            s1_pez_reg <= nz_reg * $signed({1'b0, in_ext_z});
            s1_w_reg <= nw_reg;
            s1_vx_reg <= in_vec_x;
            s1_vy_reg <= in_vec_y;
            s1_vz_reg <= in_vec_z;
            s1_ex_reg <= in_ext_x;
            s1_ey_reg <= in_ext_y;
            s1_ez_reg <= in_ext_z;
            s1_off_reg <= in_offset;
        end
    end

    always_comb
    begin
        a_next = ACC_W'(s1_pcx_reg) + ACC_W'(s1_pcy_reg) + ACC_W'(s1_pcz_reg)
                 + (ACC_W'(s1_w_reg) <<< afc_pkg::OFFSET_SHIFT);
        b_next = (s1_sgn_reg[0] ? ACC_W'(s1_pex_reg) : -ACC_W'(s1_pex_reg))
                 + (s1_sgn_reg[1] ? ACC_W'(s1_pey_reg) : -ACC_W'(s1_pey_reg))
                 + (s1_sgn_reg[2] ? ACC_W'(s1_pez_reg) : -ACC_W'(s1_pez_reg));
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && s1_valid_reg)
        begin
            s2_ctl_reg <= s1_ctl_reg;
            s2_en_reg <= s1_en_reg;
            s2_a_reg <= a_next;
            s2_b_reg <= b_next;
            s2_vx_reg <= s1_vx_reg;
            s2_vy_reg <= s1_vy_reg;
            s2_vz_reg <= s1_vz_reg;
            s2_ex_reg <= s1_ex_reg;
            s2_ey_reg <= s1_ey_reg;
            s2_ez_reg <= s1_ez_reg;
            s2_off_reg <= s1_off_reg;
        end
    end

    always_comb
    begin
        near_dist = SUM_W'(s2_a_reg) - SUM_W'(s2_b_reg);
        far_dist = SUM_W'(s2_a_reg) + SUM_W'(s2_b_reg);
        ctl3_next = s2_ctl_reg;
        ctl3_next.outside = s2_ctl_reg.outside || (s2_en_reg && (near_dist > 0));
        ctl3_next.inter = s2_ctl_reg.inter || (s2_en_reg && (far_dist > 0));
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && s2_valid_reg)
        begin
            s3_ctl_reg <= ctl3_next;
            s3_vx_reg <= s2_vx_reg;
            s3_vy_reg <= s2_vy_reg;
            s3_vz_reg <= s2_vz_reg;
            s3_ex_reg <= s2_ex_reg;
            s3_ey_reg <= s2_ey_reg;
            s3_ez_reg <= s2_ez_reg;
            s3_off_reg <= s2_off_reg;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_ctl = s3_ctl_reg;
    assign out_vec_x = s3_vx_reg;
    assign out_vec_y = s3_vy_reg;
    assign out_vec_z = s3_vz_reg;
    assign out_ext_x = s3_ex_reg;
    assign out_ext_y = s3_ey_reg;
    assign out_ext_z = s3_ez_reg;
    assign out_offset = s3_off_reg;

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for aabb_frustum_cull_core: plane loads and box tests go in under
// random sender and receiver throttling, and a scoreboard predicts each verdict exactly.
// Depends on afc_pkg and the RTL of aabb_frustum_cull_core.
`timescale 1ns / 1ps

typedef struct {
    afc_pkg::afc_op_t op;
    logic skip_far;
    logic [afc_pkg::SLOT_WIDTH-1:0] slot;
    logic signed [afc_pkg::COORD_WIDTH_DEFAULT-1:0] vec[3];
    logic [afc_pkg::COORD_WIDTH_DEFAULT-2:0] ext[3];
    logic signed [afc_pkg::COORD_WIDTH_DEFAULT-1:0] offset;
} cull_item_t;

class cull_scoreboard;
    logic signed [afc_pkg::COORD_WIDTH_DEFAULT-1:0] normal_tab[afc_pkg::PLANE_SLOTS_DEFAULT][3];
    logic signed [afc_pkg::COORD_WIDTH_DEFAULT-1:0] offset_tab[afc_pkg::PLANE_SLOTS_DEFAULT];
    logic [afc_pkg::COUNT_WIDTH-1:0] plane_count;
    logic [afc_pkg::CODES_WIDTH-1:0] codes;
    logic [1:0] expected_verdicts[$];
    int errors;
    int tests;
    int loads;
    int verdict_seen[3];

    function new();
        for (int s = 0; s < afc_pkg::PLANE_SLOTS_DEFAULT; s++)
        begin
            normal_tab[s] = '{'0, '0, '0};
            offset_tab[s] = '0;
        end
        plane_count = afc_pkg::PLANE_COUNT_RESET;
        codes = afc_pkg::CORNER_CODES_RESET;
        errors = 0;
        tests = 0;
        loads = 0;
        verdict_seen = '{0, 0, 0};
    endfunction

    function void set_register(afc_pkg::afc_reg_t r, logic [afc_pkg::DATA_WIDTH-1:0] value);
        if (r == afc_pkg::REG_PLANE_COUNT)
            plane_count = value[afc_pkg::COUNT_WIDTH-1:0];
        else
            codes = value[afc_pkg::CODES_WIDTH-1:0];
    endfunction

    // The signed distance is computed exactly in 128 bits.
    function bit corner_above(int idx, cull_item_t it, logic [afc_pkg::CODE_WIDTH-1:0] code,
                              bit far_side);
        logic signed [127:0] distance;
        logic signed [127:0] n;
        logic signed [127:0] c;
        logic signed [127:0] e;
        distance = 128'(offset_tab[idx]);
        distance = distance <<< afc_pkg::OFFSET_SHIFT;
        for (int k = 0; k < 3; k++)
        begin
            n = 128'(normal_tab[idx][k]);
            c = 128'(it.vec[k]);
            e = 128'(it.ext[k]);
            distance = distance + n * c;
            if (code[k] ^ far_side)
                distance = distance - n * e;
            else
                distance = distance + n * e;
        end
        return distance > 0;
    endfunction

    function void note_item(cull_item_t it);
        int limit;
        bit inter;
        logic [afc_pkg::CODE_WIDTH-1:0] code;
        logic [1:0] result;
        if (it.op == afc_pkg::OP_LOAD)
        begin
            loads++;
            if (it.slot < afc_pkg::PLANE_SLOTS_DEFAULT)
            begin
                normal_tab[it.slot] = it.vec;
                offset_tab[it.slot] = it.offset;
            end
            return;
        end
        limit = int'(plane_count);
        if (limit > afc_pkg::CODE_PLANES)
            limit = afc_pkg::CODE_PLANES;
        if (limit > afc_pkg::PLANE_SLOTS_DEFAULT)
            limit = afc_pkg::PLANE_SLOTS_DEFAULT;
        inter = 1'b0;
        result = afc_pkg::VERDICT_INSIDE;
        for (int i = 0; i < limit; i++)
        begin
            code = codes[afc_pkg::CODE_WIDTH*i +: afc_pkg::CODE_WIDTH];
            if (it.skip_far && i == afc_pkg::FAR_PLANE_INDEX)
                continue;
            if (code[afc_pkg::CODE_WIDTH-1])
                continue;
            if (corner_above(i, it, code, 1'b0))
            begin
                result = afc_pkg::VERDICT_OUTSIDE;
                break;
            end
            if (!inter)
                inter = corner_above(i, it, code, 1'b1);
        end
        if (result != afc_pkg::VERDICT_OUTSIDE && inter)
            result = afc_pkg::VERDICT_INTERSECT;
        tests++;
        verdict_seen[result]++;
        expected_verdicts.push_back(result);
    endfunction

    function void check_verdict(logic [1:0] got);
        logic [1:0] want;
        if (expected_verdicts.size() == 0)
        begin
            errors++;
            if (errors <= 40)
                $display("%0t: verdict mismatch, expected none, got %0d", $time, got);
            return;
        end
        want = expected_verdicts.pop_front();
        if (got !== want)
        begin
            errors++;
            if (errors <= 40)
                $display("%0t: verdict mismatch, expected %0d, got %0d", $time, want, got);
        end
    endfunction

    function int pending();
        return expected_verdicts.size();
    endfunction
endclass

module tb;
    localparam int CW = afc_pkg::COORD_WIDTH_DEFAULT;
    localparam int LATENCY = 3 * afc_pkg::PLANE_SLOTS_DEFAULT;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic signed [CW-1:0] ONE = 32'sh0001_0000;
    localparam logic [CW-2:0] EXT_ONE = (CW - 1)'(ONE);
    localparam logic [CW-2:0] EXT_TWO = (CW - 1)'(2 * ONE);

    typedef enum int
    {
        RX_OPEN,
        RX_RANDOM,
        RX_SPARSE,
        RX_BURSTY
    } rx_mode_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [afc_pkg::ADDR_WIDTH-1:0] paddr;
    logic [afc_pkg::DATA_WIDTH-1:0] pwdata;
    logic [afc_pkg::DATA_WIDTH-1:0] prdata;
    logic pready;
    logic in_valid;
    logic in_ready;
    logic operation;
    logic skip_far;
    logic [afc_pkg::SLOT_WIDTH-1:0] plane_slot;
    logic signed [CW-1:0] vec_x;
    logic signed [CW-1:0] vec_y;
    logic signed [CW-1:0] vec_z;
    logic [CW-2:0] extent_x;
    logic [CW-2:0] extent_y;
    logic [CW-2:0] extent_z;
    logic signed [CW-1:0] plane_offset;
    logic out_valid;
    logic out_ready;
    logic [1:0] verdict;

    cull_scoreboard sb;
    cull_item_t drv;
    int burst_left;
    int cycles;
    int reg_writes;
    rx_mode_t rx_mode;
    int rx_left;
    int rx_hold;
    int rx_tick;

    assign operation = drv.op;
    assign skip_far = drv.skip_far;
    assign plane_slot = drv.slot;
    assign vec_x = drv.vec[0];
    assign vec_y = drv.vec[1];
    assign vec_z = drv.vec[2];
    assign extent_x = drv.ext[0];
    assign extent_y = drv.ext[1];
    assign extent_z = drv.ext[2];
    assign plane_offset = drv.offset;

    aabb_frustum_cull_core u_top (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .operation(operation),
        .skip_far(skip_far),
        .plane_slot(plane_slot),
        .vec_x(vec_x),
        .vec_y(vec_y),
        .vec_z(vec_z),
        .extent_x(extent_x),
        .extent_y(extent_y),
        .extent_z(extent_z),
        .plane_offset(plane_offset),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .verdict(verdict)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic cull_item_t make_box(logic signed [CW-1:0] cx, logic signed [CW-1:0] cy,
                                            logic signed [CW-1:0] cz, logic [CW-2:0] ex,
                                            logic [CW-2:0] ey, logic [CW-2:0] ez, bit skip);
        cull_item_t it;
        it.op = afc_pkg::OP_TEST;
        it.skip_far = skip;
        it.slot = afc_pkg::SLOT_WIDTH'($urandom_range(0, 7));
        it.vec = '{cx, cy, cz};
        it.ext = '{ex, ey, ez};
        it.offset = $urandom;
        return it;
    endfunction

    function automatic cull_item_t make_plane(int slot, logic signed [CW-1:0] nx,
                                              logic signed [CW-1:0] ny,
                                              logic signed [CW-1:0] nz,
                                              logic signed [CW-1:0] w);
        cull_item_t it;
        it.op = afc_pkg::OP_LOAD;
        it.skip_far = 1'($urandom_range(0, 1));
        it.slot = afc_pkg::SLOT_WIDTH'(slot);
        it.vec = '{nx, ny, nz};
        it.ext = '{(CW - 1)'($urandom), (CW - 1)'($urandom), (CW - 1)'($urandom)};
        it.offset = w;
        return it;
    endfunction

    function automatic logic signed [CW-1:0] near_value(int span);
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return $signed($urandom_range(0, 2 * span * ONE)) - span * ONE;
    endfunction

    function automatic logic [CW-2:0] random_extent(int span);
        if ($urandom_range(0, 9) == 0)
            return (CW - 1)'($urandom);
        return (CW - 1)'($urandom_range(0, span * ONE));
    endfunction

    function automatic cull_item_t random_box();
        return make_box(near_value(16), near_value(16), near_value(16), random_extent(8),
                        random_extent(8), random_extent(8), 1'($urandom_range(0, 1)));
    endfunction

    function automatic cull_item_t random_plane();
        logic signed [CW-1:0] w;
        int slot;
        if ($urandom_range(0, 9) == 0)
            w = $urandom;
        else
            w = $signed($urandom_range(0, 48 * ONE)) - 40 * ONE;
        slot = ($urandom_range(0, 15) == 0) ? 7
               : $urandom_range(0, afc_pkg::PLANE_SLOTS_DEFAULT - 1);
        return make_plane(slot, near_value(2), near_value(2), near_value(2), w);
    endfunction

    task automatic send_item(cull_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        drv = it;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        burst_left = 0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_register(afc_pkg::afc_reg_t r, logic [afc_pkg::DATA_WIDTH-1:0] value);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = afc_pkg::ADDR_WIDTH'(4 * int'(r));
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_register(r, value);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        reg_writes++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_item(drv);
        if (rst_n && out_valid && out_ready)
            sb.check_verdict(verdict);
    end

    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 96);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_OPEN: out_ready = 1'b1;
            RX_RANDOM: out_ready = ($urandom_range(0, 3) != 0);
            RX_SPARSE: out_ready = (rx_tick % 5 == 0);
            default:
            begin
                if (rx_hold == 0)
                begin
                    out_ready = !out_ready;
                    rx_hold = $urandom_range(1, 12);
                end
                rx_hold--;
            end
        endcase
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: run timed out with %0d verdicts outstanding", $time, sb.pending());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        logic [afc_pkg::CODES_WIDTH-1:0] codes;
        int count;
        int n_items;
        sb = new();
        drv = make_box('0, '0, '0, '0, '0, '0, 1'b0);
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        burst_left = 0;
        cycles = 0;
        reg_writes = 0;
        rx_mode = RX_OPEN;
        rx_left = 0;
        rx_hold = 0;
        rx_tick = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_item(make_box('0, '0, '0, EXT_ONE, EXT_ONE, EXT_ONE, 1'b0));
        drain();
        write_register(afc_pkg::REG_PLANE_COUNT, 32'd7);
        write_register(afc_pkg::REG_CORNER_CODES, 32'h0375767);
        send_item(make_box(5 * ONE, '0, '0, EXT_ONE, EXT_ONE, EXT_ONE, 1'b0));
        send_item(make_plane(0, ONE, '0, '0, -10 * ONE));
        send_item(make_plane(1, -ONE, '0, '0, -10 * ONE));
        send_item(make_plane(2, '0, ONE, '0, -10 * ONE));
        send_item(make_plane(3, '0, -ONE, '0, -10 * ONE));
        send_item(make_plane(4, '0, '0, ONE, -10 * ONE));
        send_item(make_plane(5, '0, '0, -ONE, -10 * ONE));
        send_item(make_plane(6, '0, '0, '0, '0));
        send_item(make_plane(7, $urandom, $urandom, $urandom, $urandom));
        send_item(make_box('0, '0, '0, EXT_ONE, EXT_ONE, EXT_ONE, 1'b0));
        send_item(make_box(9 * ONE, '0, '0, EXT_TWO, EXT_TWO, EXT_TWO, 1'b0));
        send_item(make_box(20 * ONE, '0, '0, EXT_TWO, EXT_TWO, EXT_TWO, 1'b0));
        send_item(make_box('0, '0, -20 * ONE, EXT_ONE, EXT_ONE, EXT_ONE, 1'b0));
        send_item(make_box('0, '0, -20 * ONE, EXT_ONE, EXT_ONE, EXT_ONE, 1'b1));
        send_item(make_box(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                           31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 1'b0));
        send_item(make_box(32'sh80000000, 32'sh80000000, 32'sh80000000, '0, '0, '0, 1'b1));
        send_item(make_box('0, '0, '0, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 1'b1));
        send_item(make_box('0, '0, '0, '0, '0, '0, 1'b0));
        drain();
        write_register(afc_pkg::REG_CORNER_CODES, 32'h0375768);
        send_item(make_box(20 * ONE, '0, '0, EXT_TWO, EXT_TWO, EXT_TWO, 1'b0));

        for (int ph = 0; ph < 9; ph++)
        begin
            drain();
            if (ph == 0)
            begin
                count = 7;
                codes = '0;
            end
            else if (ph == 1)
            begin
                count = 0;
                codes = '0;
            end
            else if (ph == 2)
            begin
                count = 7;
                codes = '1;
            end
            else
            begin
                count = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 7);
                for (int p = 0; p < afc_pkg::CODE_PLANES; p++)
                    codes[afc_pkg::CODE_WIDTH*p +: afc_pkg::CODE_WIDTH] =
                        afc_pkg::CODE_WIDTH'(($urandom_range(0, 4) == 0) ?
                        $urandom_range(8, 15) : $urandom_range(0, 7));
            end
            write_register(afc_pkg::REG_PLANE_COUNT, afc_pkg::DATA_WIDTH'(count));
            write_register(afc_pkg::REG_CORNER_CODES, afc_pkg::DATA_WIDTH'(codes));
            n_items = (ph < 3) ? 40 : 130;
            for (int i = 0; i < n_items; i++)
                send_item(($urandom_range(0, 4) == 0) ? random_plane() : random_box());
        end
        drain();

        $display("Checked %0d box verdicts (%0d outside, %0d intersecting, %0d inside)",
                 sb.tests, sb.verdict_seen[afc_pkg::VERDICT_OUTSIDE],
                 sb.verdict_seen[afc_pkg::VERDICT_INTERSECT],
                 sb.verdict_seen[afc_pkg::VERDICT_INSIDE]);
        $display("alongside %0d plane loads and %0d register writes under random throttling.",
                 sb.loads, reg_writes);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
